// File: rtl/ipap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_pkg
// Shared types, constants and character helpers for the address/port parser.
// ----------------------------------------------------------------------------
package ipap_pkg;

  localparam int unsigned OCTET_CNT         = 4;
  localparam int unsigned GROUP_CNT         = 8;
  localparam int unsigned GROUP_BITS        = 16;
  localparam int unsigned OCTET_MAX         = 255;
  localparam int unsigned PORT_MAX          = 65535;
  localparam int unsigned GROUPS_ELIDED_MAX = 7;
  localparam int unsigned GROUPS_FULL       = 8;
  localparam int unsigned OCTET_DIGITS_MAX  = 3;
  localparam int unsigned PORT_DIGITS_MAX   = 5;
  localparam int unsigned GROUP_DIGITS_MAX  = 4;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef enum logic [2:0] {
    PH_START,
    PH_V4ADDR,
    PH_V4PORT,
    PH_V6IN,
    PH_V6CLOSE,
    PH_V6PORT
  } phase_t;

  typedef logic [OCTET_CNT-1:0][7:0]           oct_arr_t;
  typedef logic [GROUP_CNT-1:0][GROUP_BITS-1:0] grp_arr_t;

  // what the packer needs to lay out the address
  typedef struct packed {
    logic       v6;
    logic [3:0] head_groups;
    logic [3:0] tail_groups;
  } layout_t;

  // per-string summary on the last character
  typedef struct packed {
    logic        ok;
    logic [15:0] port;
  } summary_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // nibble of a hex digit: letters have low nibble 1..6
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] n;
    if (is_dec(c)) begin
      n = c[3:0];
    end else begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

// File: rtl/ipap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_if
// Valid/ready channels: character words in, parse result words out.
// ----------------------------------------------------------------------------
interface ipap_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ipap_res_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        family;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [15:0] port;

  modport source (output valid, output ok, output family, output addr_hi,
                  output addr_lo, output port, input ready);
  modport sink   (input valid, input ok, input family, input addr_hi,
                  input addr_lo, input port, output ready);
endinterface

// File: rtl/ip_address_port_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_port_parser
// Streaming IPv4/IPv6 address-and-port text parser, one character per word.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, sustained, with the result
//   register free or being drained.
// Result path: the last character lands in the input register, and the parse
//   step then loads the result register, raising its valid, once it has space.
// Reset: synchronous rst clears the parse state and both valid flags; the
//   octet and group stores are not cleared and are only read once written.
module ip_address_port_parser (
  input  logic        clk,
  input  logic        rst,
  ipap_char_if.sink   chars,
  ipap_res_if.source  result
);

  logic       in_full;
  logic [7:0] ch_q;
  logic       last_q;
  logic       advance;
  logic       space;

  ipap_pkg::summary_t summary;
  ipap_pkg::layout_t  layout;
  ipap_pkg::oct_arr_t octets;
  ipap_pkg::grp_arr_t head_slot;
  ipap_pkg::grp_arr_t tail_slot;
  logic [63:0]        addr_hi;
  logic [63:0]        addr_lo;

  // a word with no result never waits on the output side
  assign advance     = in_full && (!last_q || space);
  assign chars.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      ch_q   <= chars.ch;
      last_q <= chars.last;
    end
  end

  ipap_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ch        (ch_q),
    .last      (last_q),
    .summary   (summary),
    .layout    (layout),
    .octets    (octets),
    .head_slot (head_slot),
    .tail_slot (tail_slot)
  );

  ipap_addr_pack u_pack (
    .layout    (layout),
    .octets    (octets),
    .head_slot (head_slot),
    .tail_slot (tail_slot),
    .addr_hi   (addr_hi),
    .addr_lo   (addr_lo)
  );

  ipap_result_reg u_result (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && last_q),
    .summary (summary),
    .family  (layout.v6),
    .addr_hi (addr_hi),
    .addr_lo (addr_lo),
    .space   (space),
    .res     (result)
  );

endmodule

// File: rtl/ipap_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_parser
// Per-character state machine: octet, group and port accumulation, stores.
// ----------------------------------------------------------------------------
module ipap_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         ch,
  input  logic               last,
  output ipap_pkg::summary_t summary,
  output ipap_pkg::layout_t  layout,
  output ipap_pkg::oct_arr_t octets,
  output ipap_pkg::grp_arr_t head_slot,
  output ipap_pkg::grp_arr_t tail_slot
);

  ipap_pkg::phase_t phase, phase_next;
  logic        err, err_next;
  logic [15:0] fval, fval_next;
  logic [2:0]  fdig, fdig_next;
  logic        lz, lz_next;
  logic [2:0]  ocnt, ocnt_next;
  logic [3:0]  head, head_next;
  logic [3:0]  tail, tail_next;
  logic        elis, elis_next;
  logic [1:0]  crun, crun_next;
  logic [16:0] pval, pval_next;
  logic [2:0]  pdig, pdig_next;

  logic oct_wr, head_wr, tail_shift;
  logic do_v4, do_v6, do_port;

  always_comb begin
    logic [3:0] total;
    logic [3:0] dv;
    logic       push_now;
    logic [3:0] head_after;
    logic [3:0] tail_after;
    phase_next = phase;
    err_next   = err;
    fval_next  = fval;
    fdig_next  = fdig;
    lz_next    = lz;
    ocnt_next  = ocnt;
    head_next  = head;
    tail_next  = tail;
    elis_next  = elis;
    crun_next  = crun;
    pval_next  = pval;
    pdig_next  = pdig;
    oct_wr     = 1'b0;
    head_wr    = 1'b0;
    tail_shift = 1'b0;
    do_v4      = 1'b0;
    do_v6      = 1'b0;
    do_port    = 1'b0;
    total      = head + tail;
    dv         = ch[3:0];
    push_now   = 1'b0;
    head_after = head;
    tail_after = tail;

    if (step && !err) begin
      case (phase)
        ipap_pkg::PH_START: begin
          if (ch == ipap_pkg::CH_LBRACK) begin
            phase_next = ipap_pkg::PH_V6IN;
          end else begin
            phase_next = ipap_pkg::PH_V4ADDR;
            do_v4      = 1'b1;
          end
        end
        ipap_pkg::PH_V4ADDR:  do_v4 = 1'b1;
        ipap_pkg::PH_V6IN:    do_v6 = 1'b1;
        ipap_pkg::PH_V6CLOSE: begin
          if (ch == ipap_pkg::CH_COLON) begin
            phase_next = ipap_pkg::PH_V6PORT;
          end else begin
            err_next = 1'b1;
          end
        end
        ipap_pkg::PH_V4PORT,
        ipap_pkg::PH_V6PORT:  do_port = 1'b1;
        default:              err_next = 1'b1;
      endcase
    end

    if (do_v4) begin
      if (ipap_pkg::is_dec(ch)) begin
        if (32'(fdig) >= ipap_pkg::OCTET_DIGITS_MAX || lz) begin
          err_next = 1'b1;
        end else begin
          if (fdig == 3'd0 && dv == 4'd0) begin
            lz_next = 1'b1;
          end
          fval_next = 16'(fval * 16'd10) + 16'(dv);
          fdig_next = fdig + 3'd1;
        end
      end else if (ch == ipap_pkg::CH_DOT || ch == ipap_pkg::CH_COLON) begin
        if (fdig == 3'd0 || 32'(ocnt) >= ipap_pkg::OCTET_CNT
            || 32'(fval) > ipap_pkg::OCTET_MAX) begin
          err_next = 1'b1;
        end else begin
          oct_wr    = 1'b1;
          ocnt_next = ocnt + 3'd1;
          fval_next = '0;
          fdig_next = '0;
          lz_next   = 1'b0;
        end
        if (ch == ipap_pkg::CH_COLON) begin
          // the octet just closed must be the fourth
          if (32'(ocnt) != ipap_pkg::OCTET_CNT - 1) begin
            err_next = 1'b1;
          end
          phase_next = ipap_pkg::PH_V4PORT;
        end
      end else begin
        err_next = 1'b1;
      end
    end

    if (do_v6) begin
      if (ch == ipap_pkg::CH_COLON) begin
        push_now = (crun == 2'd0) && (fdig != 3'd0);
        if (push_now && 32'(total) >= ipap_pkg::GROUPS_FULL) begin
          err_next = 1'b1;
        end else if (crun == 2'd3) begin
          err_next = 1'b1;
        end else begin
          if (push_now) begin
            head_wr    = !elis;
            tail_shift = elis;
            head_next  = head + 4'(!elis);
            tail_next  = tail + 4'(elis);
            fval_next  = '0;
            fdig_next  = '0;
          end
          crun_next = crun + 2'd1;
          // second colon of a run is the elision
          if (crun == 2'd1) begin
            if (elis) begin
              err_next = 1'b1;
            end
            elis_next = 1'b1;
          end
        end
      end else if (ch == ipap_pkg::CH_RBRACK) begin
        push_now = fdig != 3'd0;
        if (crun == 2'd1 || crun == 2'd3) begin
          err_next = 1'b1;
        end else if (push_now && 32'(total) >= ipap_pkg::GROUPS_FULL) begin
          err_next = 1'b1;
        end else begin
          head_after = head + 4'(push_now && !elis);
          tail_after = tail + 4'(push_now && elis);
          if (push_now) begin
            head_wr    = !elis;
            tail_shift = elis;
            head_next  = head_after;
            tail_next  = tail_after;
            fval_next  = '0;
            fdig_next  = '0;
          end
          if (elis ? (32'(head_after + tail_after) > ipap_pkg::GROUPS_ELIDED_MAX)
                   : (32'(head_after) != ipap_pkg::GROUPS_FULL)) begin
            err_next = 1'b1;
          end else begin
            phase_next = ipap_pkg::PH_V6CLOSE;
          end
        end
      end else begin
        // a single colon may not open the address
        if (crun == 2'd1 && total == 4'd0 && !elis) begin
          err_next = 1'b1;
        end else if (!ipap_pkg::is_hex(ch)
                     || 32'(fdig) >= ipap_pkg::GROUP_DIGITS_MAX) begin
          err_next = 1'b1;
        end else begin
          crun_next = 2'd0;
          fval_next = {fval[11:0], ipap_pkg::hex_nib(ch)};
          fdig_next = fdig + 3'd1;
        end
      end
    end

    if (do_port) begin
      if (ipap_pkg::is_dec(ch) && 32'(pdig) < ipap_pkg::PORT_DIGITS_MAX) begin
        pval_next = 17'(pval * 17'd10) + 17'(dv);
        pdig_next = pdig + 3'd1;
      end else begin
        err_next = 1'b1;
      end
    end
  end

  // outputs: summary from the updated values, layout from the stores as held
  always_comb begin
    summary.ok = !err_next
                 && (phase_next == ipap_pkg::PH_V4PORT || phase_next == ipap_pkg::PH_V6PORT)
                 && (pdig_next != 3'd0) && (32'(pval_next) <= ipap_pkg::PORT_MAX);
    summary.port       = pval_next[15:0];
    layout.v6          = (phase == ipap_pkg::PH_V6PORT);
    layout.head_groups = head;
    layout.tail_groups = tail;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= ipap_pkg::PH_START;
      err   <= 1'b0;
      fval  <= '0;
      fdig  <= '0;
      lz    <= 1'b0;
      ocnt  <= '0;
      head  <= '0;
      tail  <= '0;
      elis  <= 1'b0;
      crun  <= '0;
      pval  <= '0;
      pdig  <= '0;
    end else begin
      phase <= phase_next;
      err   <= err_next;
      fval  <= fval_next;
      fdig  <= fdig_next;
      lz    <= lz_next;
      ocnt  <= ocnt_next;
      head  <= head_next;
      tail  <= tail_next;
      elis  <= elis_next;
      crun  <= crun_next;
      pval  <= pval_next;
      pdig  <= pdig_next;
    end
  end

  // tail groups shift in from the right so they end up right-aligned
  always_ff @(posedge clk) begin
    if (oct_wr) begin
      octets[ocnt[1:0]] <= fval[7:0];
    end
    if (head_wr) begin
      head_slot[head[2:0]] <= fval;
    end
    if (tail_shift) begin
      for (int i = 0; i < ipap_pkg::GROUP_CNT - 1; i++) begin
        tail_slot[i] <= tail_slot[i+1];
      end
      tail_slot[ipap_pkg::GROUP_CNT-1] <= fval;
    end
  end

`ifndef SYNTHESIS
  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    32'(head + tail) <= ipap_pkg::GROUPS_FULL)
    else $error("group count beyond eight");

  a_octet_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ocnt) <= ipap_pkg::OCTET_CNT)
    else $error("octet count beyond four");

  a_port_digits: assert property (@(posedge clk) disable iff (rst)
    32'(pdig) <= ipap_pkg::PORT_DIGITS_MAX)
    else $error("too many port digits held");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (phase == ipap_pkg::PH_START && !err && head == 4'd0
                        && tail == 4'd0 && pdig == 3'd0))
    else $error("parser not cleared after last word");
`endif

endmodule

// File: rtl/ipap_addr_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_addr_pack
// Lays out the 128-bit address from the octet and group stores.
// ----------------------------------------------------------------------------
module ipap_addr_pack (
  input  ipap_pkg::layout_t  layout,
  input  ipap_pkg::oct_arr_t octets,
  input  ipap_pkg::grp_arr_t head_slot,
  input  ipap_pkg::grp_arr_t tail_slot,
  output logic [63:0]        addr_hi,
  output logic [63:0]        addr_lo
);

  ipap_pkg::grp_arr_t w;
  logic [3:0]         tail_start;

  assign tail_start = 4'(ipap_pkg::GROUP_CNT) - layout.tail_groups;

  // head groups from the left, tail groups right-aligned, zeros between
  always_comb begin
    for (int i = 0; i < ipap_pkg::GROUP_CNT; i++) begin
      if (4'(i) < layout.head_groups) begin
        w[i] = head_slot[i];
      end else if (4'(i) >= tail_start) begin
        w[i] = tail_slot[i];
      end else begin
        w[i] = '0;
      end
    end
  end

  always_comb begin
    if (layout.v6) begin
      addr_hi = {w[0], w[1], w[2], w[3]};
      addr_lo = {w[4], w[5], w[6], w[7]};
    end else begin
      addr_hi = {octets[0], octets[1], octets[2], octets[3], 32'd0};
      addr_lo = '0;
    end
  end

endmodule

// File: rtl/ipap_result_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_result_reg
// Output register for result words, zeroing the payload of a failed parse.
// ----------------------------------------------------------------------------
module ipap_result_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ipap_pkg::summary_t summary,
  input  logic               family,
  input  logic [63:0]        addr_hi,
  input  logic [63:0]        addr_lo,
  output logic               space,
  ipap_res_if.source         res
);

  logic        pending;
  logic        ok_q;
  logic        family_q;
  logic [63:0] addr_hi_q;
  logic [63:0] addr_lo_q;
  logic [15:0] port_q;

  assign space = !pending || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (load) begin
      pending <= 1'b1;
    end else if (res.ready) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_q      <= summary.ok;
      family_q  <= summary.ok && family;
      addr_hi_q <= summary.ok ? addr_hi : 64'd0;
      addr_lo_q <= summary.ok ? addr_lo : 64'd0;
      port_q    <= summary.ok ? summary.port : 16'd0;
    end
  end

  assign res.valid   = pending;
  assign res.ok      = ok_q;
  assign res.family  = family_q;
  assign res.addr_hi = addr_hi_q;
  assign res.addr_lo = addr_lo_q;
  assign res.port    = port_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!pending || res.ready))
    else $error("result word overwritten before taken");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (pending && !ok_q) |-> (!family_q && port_q == 16'd0 && addr_hi_q == 64'd0
                            && addr_lo_q == 64'd0))
    else $error("failed parse carries payload");

  a_load_sets: assert property (@(posedge clk) disable iff (rst)
    load |=> pending)
    else $error("loaded result not presented");
`endif

endmodule
